FILE: hw/rtl/linear_array_deque_macros.svh
// Assertion macros shared by the deque checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LINEAR_ARRAY_DEQUE_MACROS_SVH
`define LINEAR_ARRAY_DEQUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lad_pkg.sv
// Shared constants, types and helper functions for the linear array deque.
// No dependencies; all deque files but lad_ram and the macro header import it.
package lad_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(DEPTH + 1) + 1;
  localparam int CAP_W  = 7;
  localparam int DATA_W = 8;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;
  localparam int CMP_W  = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

  typedef logic signed [IDX_W-1:0] idx_t;
  typedef logic signed [CMP_W-1:0] cmp_t;

  localparam idx_t IDX_UNSET = '1;
  localparam idx_t IDX_ZERO  = '0;
  localparam idx_t IDX_ONE   = idx_t'(1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK       = 3'd4,
    OP_RESET      = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE       = 2'd0,
    STAT_BACK_FULL  = 2'd1,
    STAT_FRONT_FULL = 2'd2,
    STAT_EMPTY      = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  function automatic logic deque_empty(idx_t front, idx_t back);
    return (front == IDX_UNSET) || (front > back);
  endfunction

  function automatic logic deque_full(idx_t back, logic [CAP_W-1:0] cap);
    cmp_t c;
    cmp_t b;
    c = $signed({{(CMP_W-CAP_W){1'b0}}, cap});
    b = $signed({{(CMP_W-IDX_W){back[IDX_W-1]}}, back});
    if (c == cmp_t'(0)) begin
      c = cmp_t'(1);
    end else if (c > cmp_t'(DEPTH)) begin
      c = cmp_t'(DEPTH);
    end
    return b >= (c - cmp_t'(1));
  endfunction

endpackage

FILE: hw/rtl/lad_if.sv
// Handshake channel interfaces for the deque: operation input, result output
// and capacity configuration. Depends on lad_pkg.
interface lad_in_if;
  import lad_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] data_in;
  modport source (output valid, output operation, output data_in, input ready);
  modport sink   (input valid, input operation, input data_in, output ready);
endinterface

interface lad_out_if;
  import lad_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic [STAT_W-1:0] status;
  logic              is_empty;
  logic              is_full;
  modport source (output valid, output data_out, output status, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input data_out, input status, input is_empty,
                  input is_full, output ready);
endinterface

interface lad_cfg_if;
  import lad_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;
  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

FILE: hw/rtl/lad_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/linear_array_deque.sv
// Byte deque kept in a linear slot memory with front and back indices. Pushes,
// the reset operation, unused codes and refused operations load the result
// register from the idle state; a pop or peek of a stored entry goes through the
// read state, as it waits on the registered read port of the slot memory. A new
// item is taken whenever the block is not reading and the result register is
// empty or being emptied in that cycle. Depends on lad_pkg, lad_if and lad_ram.
module linear_array_deque (
  input  logic clk,
  input  logic rst_n,
  lad_in_if.sink    in_ch,
  lad_out_if.source out_ch,
  lad_cfg_if.sink   cfg_ch
);
  import lad_pkg::*;

  state_t state_r, state_nxt;
  idx_t   front_r, front_nxt;
  idx_t   back_r, back_nxt;
  logic [CAP_W-1:0] cap_r;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  status_t           status_r, status_nxt;
  logic              empty_r, empty_nxt;
  logic              full_r, full_nxt;

  logic              accept;
  logic              empty_now;
  logic              needs_read;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  status_t           res_status;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign empty_now   = deque_empty(front_r, back_r);
  assign needs_read  = !empty_now &&
                       (in_ch.operation inside {OP_POP_FRONT, OP_POP_BACK, OP_PEEK});
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && needs_read) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    front_nxt     = front_r;
    back_nxt      = back_r;
    ram_we        = 1'b0;
    ram_waddr     = back_r[ADDR_W-1:0];
    ram_re        = 1'b0;
    ram_raddr     = front_r[ADDR_W-1:0];
    res_status    = STAT_DONE;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    data_nxt      = data_r;
    status_nxt    = status_r;
    empty_nxt     = empty_r;
    full_nxt      = full_r;
    case (state_r)
      ST_READ: begin
        out_valid_nxt = 1'b1;
        data_nxt      = ram_rdata;
        status_nxt    = STAT_DONE;
        empty_nxt     = deque_empty(front_r, back_r);
        full_nxt      = deque_full(back_r, cap_r);
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.operation)
            OP_PUSH_BACK: begin
              if (deque_full(back_r, cap_r)) begin
                res_status = STAT_BACK_FULL;
              end else begin
                if ((back_r == IDX_UNSET) && (front_r == IDX_UNSET)) begin
                  front_nxt = IDX_ZERO;
                end
                back_nxt  = back_r + IDX_ONE;
                ram_we    = 1'b1;
                ram_waddr = back_nxt[ADDR_W-1:0];
              end
            end
            OP_PUSH_FRONT: begin
              if (front_r < IDX_ONE) begin
                res_status = STAT_FRONT_FULL;
              end else begin
                front_nxt = front_r - IDX_ONE;
                ram_we    = 1'b1;
                ram_waddr = front_nxt[ADDR_W-1:0];
              end
            end
            OP_POP_FRONT: begin
              if (empty_now) begin
                res_status = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_r[ADDR_W-1:0];
                front_nxt = front_r + IDX_ONE;
              end
            end
            OP_POP_BACK: begin
              if (empty_now) begin
                res_status = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = back_r[ADDR_W-1:0];
                back_nxt  = back_r - IDX_ONE;
              end
            end
            OP_PEEK: begin
              if (empty_now) begin
                res_status = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_r[ADDR_W-1:0];
              end
            end
            OP_RESET: begin
              front_nxt = IDX_UNSET;
              back_nxt  = IDX_UNSET;
            end
            default: begin
              res_status = STAT_DONE;
            end
          endcase
          if (!needs_read) begin
            out_valid_nxt = 1'b1;
            data_nxt      = '0;
            status_nxt    = res_status;
            empty_nxt     = deque_empty(front_nxt, back_nxt);
            full_nxt      = deque_full(back_nxt, cap_r);
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ch.ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= IDX_UNSET;
      back_r      <= IDX_UNSET;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        cap_r <= cfg_ch.capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    status_r <= status_nxt;
    empty_r  <= empty_nxt;
    full_r   <= full_nxt;
  end

  lad_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_ch.data_in),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = data_r;
  assign out_ch.status   = status_r;
  assign out_ch.is_empty = empty_r;
  assign out_ch.is_full  = full_r;

endmodule

FILE: hw/rtl/lad_checker.sv
// Port-level checks on the deque result channel, bound to the top level.
// Depends on lad_pkg and linear_array_deque_macros.svh.
`include "linear_array_deque_macros.svh"

module lad_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [lad_pkg::DATA_W-1:0] data_out,
  input logic [lad_pkg::STAT_W-1:0] status,
  input logic                      is_empty,
  input logic                      is_full
);
  import lad_pkg::*;

  `LAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(data_out) && $stable(status), "result item changed while stalled")
  `LAD_ASSERT_IMP(a_refused_no_data, out_valid && (status != STAT_DONE),
    data_out == '0, "refused item carries data")
  `LAD_ASSERT_IMP(a_empty_flag, out_valid && (status == STAT_EMPTY),
    is_empty, "empty refusal without empty flag")
  `LAD_ASSERT_IMP(a_full_flag, out_valid && (status == STAT_BACK_FULL),
    is_full, "back full refusal without full flag")

endmodule

bind linear_array_deque lad_checker u_lad_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .data_out (out_ch.data_out),
  .status   (out_ch.status),
  .is_empty (out_ch.is_empty),
  .is_full  (out_ch.is_full)
);

FILE: tb/linear_array_deque_checker.sv
// Result checker for the linear array deque: keeps its own copy of the slot store,
// both indices and the capacity, and compares every result item in order.
// Depends on lad_pkg and the channel interfaces in lad_if.
module linear_array_deque_checker (
  input  logic      clk,
  input  logic      rst_n,
  lad_in_if         in_ch,
  lad_out_if        out_ch,
  lad_cfg_if        cfg_ch,
  output int        mismatches,
  output int        pending
);
  import lad_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic              empty;
    logic              full;
  } deque_result_t;

  logic [DATA_W-1:0] slot_mem [DEPTH];
  int                front_pos;
  int                back_pos;
  logic [CAP_W-1:0]  capacity_reg;
  deque_result_t     awaited_results [$];

  function automatic int usable_slots();
    if (capacity_reg == '0) return 1;
    if (capacity_reg > CAP_W'(DEPTH)) return DEPTH;
    return int'(capacity_reg);
  endfunction

  function automatic bit holds_nothing();
    return (front_pos == -1) || (front_pos > back_pos);
  endfunction

  function automatic deque_result_t deque_outcome(input logic [OP_W-1:0] op,
                                                  input logic [DATA_W-1:0] din);
    deque_result_t r;
    int            limit;
    limit = usable_slots();
    r.data = '0;
    r.status = STAT_DONE;
    case (op)
      OP_PUSH_BACK: begin
        if (back_pos >= limit - 1) begin
          r.status = STAT_BACK_FULL;
        end else begin
          if (back_pos == -1 && front_pos == -1) front_pos = 0;
          back_pos++;
          slot_mem[back_pos] = din;
        end
      end
      OP_PUSH_FRONT: begin
        if (front_pos < 1) begin
          r.status = STAT_FRONT_FULL;
        end else begin
          front_pos--;
          slot_mem[front_pos] = din;
        end
      end
      OP_POP_FRONT: begin
        if (holds_nothing()) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data = slot_mem[front_pos];
          front_pos++;
        end
      end
      OP_POP_BACK: begin
        if (holds_nothing()) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data = slot_mem[back_pos];
          back_pos--;
        end
      end
      OP_PEEK: begin
        if (holds_nothing()) r.status = STAT_EMPTY;
        else r.data = slot_mem[front_pos];
      end
      OP_RESET: begin
        front_pos = -1;
        back_pos = -1;
      end
      default: ;
    endcase
    r.empty = holds_nothing();
    r.full = (back_pos >= limit - 1);
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t seen;
    deque_result_t want;
    if (!rst_n) begin
      front_pos = -1;
      back_pos = -1;
      capacity_reg = CAP_RESET;
      awaited_results.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) capacity_reg = cfg_ch.capacity;
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.data_out, status_t'(out_ch.status), out_ch.is_empty,
                 out_ch.is_full};
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result item, expected none, %s %02h %0d %0b %0b",
                   $time, "got data/status/empty/full", seen.data, seen.status,
                   seen.empty, seen.full);
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            $display("%0t: expected data %02h status %0d empty %0b full %0b,",
                     $time, want.data, want.status, want.empty, want.full);
            $display("%0t:      got data %02h status %0d empty %0b full %0b",
                     $time, seen.data, seen.status, seen.empty, seen.full);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited_results.push_back(deque_outcome(in_ch.operation, in_ch.data_in));
      pending <= awaited_results.size();
    end
  end

endmodule

FILE: tb/linear_array_deque_test.sv
// Top of the deque testbench: clock, reset, directed and random operation items,
// capacity writes, result back-pressure, watchdog and the final verdict.
// Depends on lad_pkg, lad_if, linear_array_deque and linear_array_deque_checker.
module linear_array_deque_test;
  import lad_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LOW  = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HIGH = 3'd7;
  localparam int              IDLE_LIMIT    = 2000;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   idle_cycles = 0;
  bit   no_idle = 0;
  bit   filling = 1;

  lad_in_if  in_ch ();
  lad_out_if out_ch ();
  lad_cfg_if cfg_ch ();

  linear_array_deque uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  linear_array_deque_checker checker_inst (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OP_W-1:0] pick_operation();
    int unsigned r;
    r = $urandom_range(0, 199);
    if (filling) begin
      if (r < 90) return OP_PUSH_BACK;
      if (r < 120) return OP_PUSH_FRONT;
      if (r < 144) return OP_POP_FRONT;
      if (r < 160) return OP_POP_BACK;
      if (r < 180) return OP_PEEK;
      if (r < 181) return OP_RESET;
      if (r < 191) return OP_SPARE_LOW;
      return OP_SPARE_HIGH;
    end
    if (r < 30) return OP_PUSH_BACK;
    if (r < 54) return OP_PUSH_FRONT;
    if (r < 104) return OP_POP_FRONT;
    if (r < 154) return OP_POP_BACK;
    if (r < 178) return OP_PEEK;
    if (r < 182) return OP_RESET;
    if (r < 191) return OP_SPARE_LOW;
    return OP_SPARE_HIGH;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] din);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_in <= din;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.capacity <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned hold;
    int unsigned r;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(0, 19);
        end else if (r < 90) begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(0, 2);
        end else if (r < 97) begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(9, 39);
        end else begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(100, 300);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CAP_W-1:0] cap;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_PUSH_BACK;
    in_ch.data_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.capacity = CAP_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_capacity(CAP_W'(64));
    send_item(OP_POP_FRONT, 8'h11);
    send_item(OP_POP_BACK, 8'h22);
    send_item(OP_PEEK, 8'h33);
    send_item(OP_PUSH_FRONT, 8'h44);
    send_item(OP_SPARE_LOW, 8'hFF);
    send_item(OP_SPARE_HIGH, 8'h80);
    send_item(OP_PUSH_BACK, 8'h00);
    send_item(OP_PUSH_BACK, 8'hFF);
    send_item(OP_PUSH_BACK, 8'hA5);
    send_item(OP_PEEK, 8'h00);
    send_item(OP_PUSH_FRONT, 8'h77);
    send_item(OP_POP_FRONT, 8'h00);
    send_item(OP_PUSH_FRONT, 8'h5A);
    send_item(OP_POP_BACK, 8'h00);
    send_item(OP_POP_FRONT, 8'h00);
    send_item(OP_POP_FRONT, 8'h00);
    send_item(OP_POP_BACK, 8'h00);
    send_item(OP_PUSH_FRONT, 8'h3C);
    send_item(OP_POP_BACK, 8'h00);
    send_item(OP_RESET, 8'h00);
    send_item(OP_PUSH_BACK, 8'h01);
    send_item(OP_PUSH_BACK, 8'h02);
    send_item(OP_PUSH_BACK, 8'h04);

    // A capacity below the current fill leaves the back end full.
    write_capacity(CAP_W'(2));
    send_item(OP_PUSH_BACK, 8'h08);
    send_item(OP_POP_BACK, 8'h00);

    write_capacity(CAP_W'(0));
    send_item(OP_RESET, 8'h00);
    send_item(OP_PUSH_BACK, 8'h10);
    send_item(OP_PUSH_BACK, 8'h20);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: cap = CAP_W'(127);
        1: cap = CAP_W'(2);
        2: cap = CAP_W'(0);
        3: cap = CAP_W'(64);
        4: cap = CAP_W'(1);
        5: cap = CAP_W'($urandom_range(3, 63));
        6: cap = CAP_W'($urandom_range(65, 126));
        default: cap = CAP_W'($urandom_range(1, 64));
      endcase
      write_capacity(cap);
      for (int n = 0; n < 190; n++) begin
        if (n % 40 == 0) begin
          filling = ($urandom_range(0, 2) != 0);
          no_idle = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 299) == 0) wait_drained();
        send_item(pick_operation(), DATA_W'($urandom));
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
